// File: rtl/core/rmv_pkg.sv
`timescale 1ns / 1ps

package rmv_pkg;

    // Item fields.
    localparam int SAMPLE_W       = 8;
    localparam int COUNT_WIDTH    = 32;
    localparam int MEAN_FRAC_BITS = 16;
    localparam int MEAN_W         = SAMPLE_W + MEAN_FRAC_BITS;
    localparam int SUM_FRAC_BITS  = 8;
    localparam int SUM_W          = 56;

    // Internal arithmetic. A deviation from the mean spans two sample ranges,
    // so its magnitude still fits in MEAN_W bits.
    localparam int DELTA_W    = MEAN_W + 1;
    localparam int MAG_W      = MEAN_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int PROD_SHIFT = 2 * MEAN_FRAC_BITS - SUM_FRAC_BITS;
    localparam int ADD_W      = PROD_W - PROD_SHIFT;
    localparam int DIV_CNT_W  = $clog2(MAG_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DEV,
        ST_MUL,
        ST_ACC
    } state_t;

endpackage

// File: rtl/core/rmv_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle through one shared
// compare-and-subtract unit.
module rmv_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [rmv_pkg::MAG_W-1:0]        dividend,
    input  logic [rmv_pkg::COUNT_WIDTH-1:0]  divisor,
    output logic                             done,
    output logic [rmv_pkg::MAG_W-1:0]        quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [rmv_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [rmv_pkg::MAG_W-1:0]        quo_reg;
    logic [rmv_pkg::COUNT_WIDTH-1:0]  rem_reg;
    logic [rmv_pkg::COUNT_WIDTH-1:0]  divisor_reg;

    logic [rmv_pkg::COUNT_WIDTH:0]    trial;
    logic [rmv_pkg::COUNT_WIDTH:0]    diff;
    logic                             fits;
    logic [rmv_pkg::COUNT_WIDTH-1:0]  rem_next;

    assign trial = {rem_reg, quo_reg[rmv_pkg::MAG_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});
    // The partial remainder stays below the divisor, so it never needs the top bit.
    assign rem_next = fits ? diff[rmv_pkg::COUNT_WIDTH-1:0]
                           : trial[rmv_pkg::COUNT_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= rmv_pkg::DIV_CNT_W'(rmv_pkg::MAG_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[rmv_pkg::MAG_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/running_mean_variance_unit.sv
`timescale 1ns / 1ps

// Running mean and variance (Welford) over signed byte samples.
// Input channel: s_valid / s_ready with s_sample, one signed byte per word.
// Result channel: m_valid / m_ready with the updated sample count, the
// running mean (16 fraction bits) and the sum of squared deviations
// (8 fraction bits); one result word per input word.
// Each sample runs through a 24-bit serial divider, then through the mean
// update, the deviation, the multiply and the accumulate, in that order.
// A result becomes valid in the same cycle that s_ready rises again, so the
// block takes no new sample until the last one has reached the output register.
// The divider's one-bit-per-cycle loop is the longest of these steps.
// The result sits in an output register; if the receiver stalls, the block
// holds the next finished sample in its accumulate step until the register
// frees up, and takes no new sample meanwhile.
// Reset (aresetn low at a clock edge) clears the count, the mean and the
// sum, and drops any result not yet taken. Count and sum saturate.
module running_mean_variance_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rmv_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rmv_pkg::COUNT_WIDTH-1:0]     m_count_out,
    output logic signed [rmv_pkg::MEAN_W-1:0]   m_mean_out,
    output logic [rmv_pkg::SUM_W-1:0]           m_sum_sq_dev_out
);

    rmv_pkg::state_t state_reg, state_next;

    logic [rmv_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [rmv_pkg::MEAN_W-1:0]      mean_reg;
    logic [rmv_pkg::SUM_W-1:0]       sum_reg;
    logic [rmv_pkg::MEAN_W-1:0]      xs_reg;
    logic                            dneg_reg;
    logic [rmv_pkg::MAG_W-1:0]       dmag_reg;
    logic                            vneg_reg;
    logic [rmv_pkg::MAG_W-1:0]       vmag_reg;
    logic                            opp_reg;
    logic [rmv_pkg::PROD_W-1:0]      prod_reg;

    logic                            m_valid_reg;
    logic [rmv_pkg::COUNT_WIDTH-1:0] m_count_reg;
    logic [rmv_pkg::MEAN_W-1:0]      m_mean_reg;
    logic [rmv_pkg::SUM_W-1:0]       m_sum_reg;

    // Control decoded from the state, the handshakes and the divider.
    logic accept;
    logic out_free;
    logic load_mean;
    logic load_dev;
    logic load_prod;
    logic load_out;

    // Datapath.
    logic [rmv_pkg::MEAN_W-1:0]      xs;
    logic [rmv_pkg::COUNT_WIDTH-1:0] count_next;
    logic [rmv_pkg::DELTA_W-1:0]     delta;
    logic [rmv_pkg::DELTA_W-1:0]     delta_abs;
    logic [rmv_pkg::DELTA_W-1:0]     dev;
    logic [rmv_pkg::DELTA_W-1:0]     dev_abs;
    logic [rmv_pkg::DELTA_W-1:0]     mean_wide;
    logic [rmv_pkg::DELTA_W-1:0]     step_wide;
    logic [rmv_pkg::DELTA_W-1:0]     mean_upd;
    logic [rmv_pkg::ADD_W-1:0]       add;
    logic [rmv_pkg::SUM_W:0]         sum_wide;
    logic [rmv_pkg::SUM_W-1:0]       sum_next;
    logic                            div_done;
    logic [rmv_pkg::MAG_W-1:0]       div_quo;

    assign xs = {s_sample, {rmv_pkg::MEAN_FRAC_BITS{1'b0}}};
    assign count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    assign delta     = {xs[rmv_pkg::MEAN_W-1], xs} - {mean_reg[rmv_pkg::MEAN_W-1], mean_reg};
    assign delta_abs = delta[rmv_pkg::DELTA_W-1] ? (~delta + 1'b1) : delta;

    assign mean_wide = {mean_reg[rmv_pkg::MEAN_W-1], mean_reg};
    assign step_wide = {1'b0, div_quo};
    assign mean_upd  = dneg_reg ? (mean_wide - step_wide) : (mean_wide + step_wide);

    assign dev     = {xs_reg[rmv_pkg::MEAN_W-1], xs_reg}
                   - {mean_reg[rmv_pkg::MEAN_W-1], mean_reg};
    assign dev_abs = dev[rmv_pkg::DELTA_W-1] ? (~dev + 1'b1) : dev;

    // A product of opposite-signed deviations never adds to the sum.
    assign add      = opp_reg ? '0 : prod_reg[rmv_pkg::PROD_W-1:rmv_pkg::PROD_SHIFT];
    assign sum_wide = {1'b0, sum_reg} + {{(rmv_pkg::SUM_W + 1 - rmv_pkg::ADD_W){1'b0}}, add};
    assign sum_next = sum_wide[rmv_pkg::SUM_W] ? '1 : sum_wide[rmv_pkg::SUM_W-1:0];

    assign out_free = !m_valid_reg || m_ready;

    rmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (delta_abs[rmv_pkg::MAG_W-1:0]),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rmv_pkg::ST_DIV;
                end
            end
            rmv_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rmv_pkg::ST_DEV;
                end
            end
            rmv_pkg::ST_DEV: begin
                state_next = rmv_pkg::ST_MUL;
            end
            rmv_pkg::ST_MUL: begin
                state_next = rmv_pkg::ST_ACC;
            end
            rmv_pkg::ST_ACC: begin
                if (out_free) begin
                    state_next = rmv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        load_mean = 1'b0;
        load_dev  = 1'b0;
        load_prod = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            rmv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            rmv_pkg::ST_DIV: begin
                load_mean = div_done;
            end
            rmv_pkg::ST_DEV: begin
                load_dev = 1'b1;
            end
            rmv_pkg::ST_MUL: begin
                load_prod = 1'b1;
            end
            rmv_pkg::ST_ACC: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmv_pkg::ST_IDLE;
            count_reg   <= '0;
            mean_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg <= count_next;
            end
            if (load_mean) begin
                mean_reg <= mean_upd[rmv_pkg::MEAN_W-1:0];
            end
            if (load_out) begin
                sum_reg     <= sum_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            xs_reg   <= xs;
            dneg_reg <= delta[rmv_pkg::DELTA_W-1];
            dmag_reg <= delta_abs[rmv_pkg::MAG_W-1:0];
        end
        if (load_dev) begin
            vneg_reg <= dev[rmv_pkg::DELTA_W-1];
            vmag_reg <= dev_abs[rmv_pkg::MAG_W-1:0];
        end
        if (load_prod) begin
            prod_reg <= dmag_reg * vmag_reg;
            opp_reg  <= dneg_reg ^ vneg_reg;
        end
        if (load_out) begin
            m_count_reg <= count_reg;
            m_mean_reg  <= mean_reg;
            m_sum_reg   <= sum_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_count_out      = m_count_reg;
    assign m_mean_out       = $signed(m_mean_reg);
    assign m_sum_sq_dev_out = m_sum_reg;

endmodule
